/* src/rcm_pkg.sv */
package rcm_pkg;

  // Default sizes of the block.
  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 256;

  // Fixed field widths.
  localparam int SAMPLE_W = 16;
  localparam int ROW_W    = 6;
  localparam int CORR_W   = 16;
  localparam int COLS_W   = 9;
  localparam int ROWS_W   = 7;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Normalisation arithmetic widths.
  localparam int M_W     = 24;
  localparam int Q_W     = 64;
  localparam int ROOT_W  = 32;
  localparam int NUM_W   = 40;
  localparam int QUO_W   = 17;
  localparam int SQRT_IT = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // Status of the normaliser towards its neighbours.
  typedef struct packed {
    logic done;
    logic deg;
  } norm_stat_t;

endpackage

/* src/rcm_div.sv */
module rcm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [rcm_pkg::NUM_W-1:0]  num,
  input  logic [rcm_pkg::ROOT_W-1:0] den,
  output logic [rcm_pkg::QUO_W-1:0]  quo,
  output logic                      done
);

  localparam int KW = $clog2(rcm_pkg::QUO_W);
  localparam int SW = rcm_pkg::ROOT_W + rcm_pkg::QUO_W;

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [rcm_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [rcm_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [SW-1:0]  den_sh;

  // One quotient bit per cycle, most significant first.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_sh   = SW'(den) << k_r;
    if (go) begin
      busy_nxt = 1'b1;
      k_nxt    = KW'(rcm_pkg::QUO_W - 1);
      rem_nxt  = num;
      quo_nxt  = '0;
    end else if (busy_r) begin
      if (SW'(rem_r) >= den_sh) begin
        rem_nxt      = rem_r - rcm_pkg::NUM_W'(den_sh);
        quo_nxt[k_r] = 1'b1;
      end
      if (k_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        k_nxt = k_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    k_r   <= k_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

/* src/rcm_norm.sv */
module rcm_norm #(
  parameter int MAX_ROWS = rcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rcm_pkg::MAX_COLS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS),
  localparam int NW = $clog2(MAX_COLS + 1),
  localparam int SW = NW + 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [RW-1:0]                       a,
  input  logic [NW-1:0]                       n,
  input  logic signed [SW-1:0]                sum,
  input  logic                                cur_we,
  input  logic [CW-1:0]                       cur_addr,
  input  logic signed [rcm_pkg::SAMPLE_W-1:0] cur_data,
  output logic                                nw_we,
  output logic [RW+CW-1:0]                    nw_addr,
  output logic signed [rcm_pkg::CORR_W-1:0]   nw_data,
  output rcm_pkg::norm_stat_t                 stat
);

  localparam int DW  = NW + 18;
  localparam int MW  = (DW > 25) ? DW : 25;
  localparam int SHW = $clog2(MW + 1);
  localparam int ITW = $clog2(rcm_pkg::SQRT_IT);
  localparam int PW  = 2 * rcm_pkg::M_W;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_MAX   = 3'd1;
  localparam logic [2:0] N_SHIFT = 3'd2;
  localparam logic [2:0] N_SQ    = 3'd3;
  localparam logic [2:0] N_SQRT  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;
  localparam logic [2:0] N_ZERO  = 3'd6;
  localparam logic [2:0] N_DONE  = 3'd7;

  localparam logic [2:0] PH_ADDR = 3'd0;
  localparam logic [2:0] PH_DEV  = 3'd1;
  localparam logic [2:0] PH_MAG  = 3'd2;
  localparam logic [2:0] PH_OP   = 3'd3;
  localparam logic [2:0] PH_END  = 3'd4;

  // Samples of the row being gathered.
  logic signed [rcm_pkg::SAMPLE_W-1:0] cur_mem [MAX_COLS];
  logic signed [rcm_pkg::SAMPLE_W-1:0] cur_q;

  logic [2:0]              st_r, st_nxt, ph_r, ph_nxt;
  logic [NW-1:0]           i_r, i_nxt;
  logic [RW-1:0]           a_r, a_nxt;
  logic signed [DW-1:0]    d_r, d_nxt;
  logic [MW-1:0]           mx_r, mx_nxt;
  logic [SHW-1:0]          up_r, up_nxt, dn_r, dn_nxt;
  logic [rcm_pkg::M_W-1:0] m_r, m_nxt;
  logic                    neg_r, neg_nxt;
  logic [PW-1:0]           prod_r, prod_nxt;
  logic [rcm_pkg::Q_W-1:0] q_r, q_nxt, res_r, res_nxt, bit_r, bit_nxt, trial;
  logic [ITW-1:0]          it_r, it_nxt;
  logic                    deg_r, deg_nxt;

  logic [DW-1:0]           mag;
  logic [MW-1:0]           mag_ext, m_full;
  logic                    last_elem;
  logic [rcm_pkg::ROOT_W-1:0] root;
  logic                    div_go, div_done;
  logic [rcm_pkg::NUM_W-1:0] div_num;
  logic [rcm_pkg::QUO_W-1:0] quo;
  logic signed [rcm_pkg::CORR_W-1:0] val;

  // Sample store: written by the input side, read every cycle here.
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[cur_addr] <= cur_data;
    end
    cur_q <= cur_mem[i_r[CW-1:0]];
  end

  assign mag       = d_r[DW-1] ? DW'(-d_r) : DW'(d_r);
  assign mag_ext   = MW'(mag);
  assign m_full    = (up_r != '0) ? (mag_ext << up_r) : (mag_ext >> dn_r);
  assign last_elem = (i_r == n - 1'b1);
  assign root      = res_r[rcm_pkg::ROOT_W-1:0];
  assign trial     = res_r + bit_r;
  assign div_num   = rcm_pkg::NUM_W'({m_r, 15'b0}) + rcm_pkg::NUM_W'(root >> 1);

  rcm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (div_num),
    .den  (root),
    .quo  (quo),
    .done (div_done)
  );

  // Sign and limit the quotient.
  always_comb begin
    if (neg_r) begin
      val = (quo > rcm_pkg::QUO_W'(32768)) ? rcm_pkg::CORR_W'(-32768)
                                            : rcm_pkg::CORR_W'(-quo);
    end else begin
      val = (quo > rcm_pkg::QUO_W'(32767)) ? rcm_pkg::CORR_W'(32767)
                                            : rcm_pkg::CORR_W'(quo);
    end
  end

  // Sequencer: maximum pass, scaling, sum of squares, root, division pass, zero fill.
  always_comb begin
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    i_nxt    = i_r;
    a_nxt    = a_r;
    d_nxt    = d_r;
    mx_nxt   = mx_r;
    up_nxt   = up_r;
    dn_nxt   = dn_r;
    m_nxt    = m_r;
    neg_nxt  = neg_r;
    prod_nxt = prod_r;
    q_nxt    = q_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    it_nxt   = it_r;
    deg_nxt  = deg_r;
    div_go   = 1'b0;
    nw_we    = 1'b0;
    nw_data  = val;
    stat     = '0;
    if ((st_r == N_MAX) || (st_r == N_SQ) || (st_r == N_DIV)) begin
      case (ph_r)
        PH_ADDR: ph_nxt = PH_DEV;
        PH_DEV: begin
          d_nxt  = DW'($signed({1'b0, n})) * DW'(cur_q) - DW'(sum);
          ph_nxt = PH_MAG;
        end
        PH_MAG: begin
          m_nxt   = m_full[rcm_pkg::M_W-1:0];
          neg_nxt = d_r[DW-1];
          ph_nxt  = PH_OP;
        end
        PH_OP: begin
          prod_nxt = PW'(m_r) * PW'(m_r);
          div_go   = (st_r == N_DIV);
          ph_nxt   = PH_END;
        end
        default: ph_nxt = PH_ADDR;
      endcase
    end
    case (st_r)
      N_IDLE: begin
        if (go) begin
          st_nxt = N_MAX;
          ph_nxt = PH_ADDR;
          i_nxt  = '0;
          a_nxt  = a;
          mx_nxt = '0;
          up_nxt = '0;
          dn_nxt = '0;
        end
      end
      N_MAX: begin
        if (ph_r == PH_MAG) begin
          ph_nxt = PH_ADDR;
          if (mag_ext > mx_r) begin
            mx_nxt = mag_ext;
          end
          if (last_elem) begin
            if ((mag_ext == '0) && (mx_r == '0)) begin
              deg_nxt = 1'b1;
              st_nxt  = N_DONE;
            end else begin
              deg_nxt = 1'b0;
              st_nxt  = N_SHIFT;
            end
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      N_SHIFT: begin
        if (mx_r < MW'(1 << 23)) begin
          mx_nxt = mx_r << 1;
          up_nxt = up_r + 1'b1;
        end else if (mx_r >= MW'(1 << 24)) begin
          mx_nxt = mx_r >> 1;
          dn_nxt = dn_r + 1'b1;
        end else begin
          st_nxt = N_SQ;
          ph_nxt = PH_ADDR;
          i_nxt  = '0;
          q_nxt  = '0;
        end
      end
      N_SQ: begin
        if (ph_r == PH_END) begin
          q_nxt  = q_r + rcm_pkg::Q_W'(prod_r);
          ph_nxt = PH_ADDR;
          if (last_elem) begin
            st_nxt  = N_SQRT;
            res_nxt = '0;
            bit_nxt = rcm_pkg::Q_W'(1) << 62;
            it_nxt  = '0;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
      end
      N_SQRT: begin
        // Two bits of the radicand per cycle.
        if (q_r >= trial) begin
          q_nxt   = q_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        it_nxt  = it_r + 1'b1;
        if (it_r == ITW'(rcm_pkg::SQRT_IT - 1)) begin
          st_nxt = N_DIV;
          ph_nxt = PH_ADDR;
          i_nxt  = '0;
        end
      end
      N_DIV: begin
        if ((ph_r == PH_END) && !div_done) begin
          ph_nxt = PH_END;
        end else if (ph_r == PH_END) begin
          nw_we  = 1'b1;
          ph_nxt = PH_ADDR;
          i_nxt  = i_r + 1'b1;
          if (last_elem) begin
            st_nxt = (n < NW'(MAX_COLS)) ? N_ZERO : N_DONE;
          end
        end
      end
      N_ZERO: begin
        // Columns beyond the row length read as zero later on.
        nw_we   = 1'b1;
        nw_data = '0;
        if (i_r == NW'(MAX_COLS - 1)) begin
          st_nxt = N_DONE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      N_DONE: begin
        stat.done = 1'b1;
        stat.deg  = deg_r;
        st_nxt    = N_IDLE;
      end
      default: st_nxt = N_IDLE;
    endcase
  end

  assign nw_addr = {a_r, i_r[CW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= N_IDLE;
      ph_r <= PH_ADDR;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
    end
    i_r    <= i_nxt;
    a_r    <= a_nxt;
    d_r    <= d_nxt;
    mx_r   <= mx_nxt;
    up_r   <= up_nxt;
    dn_r   <= dn_nxt;
    m_r    <= m_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    q_r    <= q_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    it_r   <= it_nxt;
    deg_r  <= deg_nxt;
  end

endmodule

/* src/rcm_corr.sv */
module rcm_corr #(
  parameter int MAX_ROWS = rcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rcm_pkg::MAX_COLS_DEF,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS),
  localparam int NW = $clog2(MAX_COLS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                go,
  input  logic [RW-1:0]                       a,
  input  logic                                fin,
  input  logic [NW-1:0]                       n,
  input  logic                                nw_we,
  input  logic [RW+CW-1:0]                    nw_addr,
  input  logic signed [rcm_pkg::CORR_W-1:0]   nw_data,
  input  rcm_pkg::norm_stat_t                 stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rcm_pkg::ROW_W-1:0]           out_row_a,
  output logic [rcm_pkg::ROW_W-1:0]           out_row_b,
  output logic signed [rcm_pkg::CORR_W-1:0]   out_correlation,
  output logic                                out_degenerate,
  output logic                                out_last,
  output logic                                out_matrix_done,
  output logic                                done
);

  localparam int CAW = 32 + NW;

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_PAIR  = 3'd1;
  localparam logic [2:0] C_MAC   = 3'd2;
  localparam logic [2:0] C_RES   = 3'd3;
  localparam logic [2:0] C_FIRST = 3'd4;

  localparam logic signed [CAW-1:0] SAT_HI = CAW'(32767);
  localparam logic signed [CAW-1:0] SAT_LO = -CAW'(32768);

  // Normalised rows, one row per block of MAX_COLS entries.
  logic signed [rcm_pkg::CORR_W-1:0] row_mem [2**(RW+CW)];
  logic signed [rcm_pkg::CORR_W-1:0] rd_a, rd_b;
  logic                              deg_mem [MAX_ROWS];
  logic                              deg_q;

  logic [2:0]            st_r, st_nxt;
  logic [RW-1:0]         a_r, a_nxt, b_r, b_nxt, deg_idx;
  logic                  fin_r, fin_nxt, dega_r, dega_nxt;
  logic [NW-1:0]         ia_r, ia_nxt;
  logic                  v1_r, v1_nxt, v2_r, v2_nxt;
  logic signed [31:0]    prod_r, prod_nxt;
  logic signed [CAW-1:0] c_r, c_nxt, rnd;
  logic                  rdeg_r, rdeg_nxt;
  logic signed [rcm_pkg::CORR_W-1:0] corr;
  logic                  issue, load;

  logic                  ov_r, ov_nxt;
  logic [RW-1:0]         oa_r, ob_r;
  logic signed [rcm_pkg::CORR_W-1:0] oc_r;
  logic                  od_r, ol_r, om_r;

  always_ff @(posedge clk) begin
    if (nw_we) begin
      row_mem[nw_addr] <= nw_data;
    end
    rd_a <= row_mem[{a_r, ia_r[CW-1:0]}];
    rd_b <= row_mem[{b_r, ia_r[CW-1:0]}];
  end

  // Zero-variance flag of each stored row, read through a register ahead of its use.
  always_ff @(posedge clk) begin
    if (stat.done) begin
      deg_mem[a] <= stat.deg;
    end
    deg_q <= deg_mem[deg_idx];
  end

  // Row a while idle, row 0 for the first pair, then the next row b.
  always_comb begin
    case (st_r)
      C_IDLE:  deg_idx = a;
      C_RES:   deg_idx = b_r + 1'b1;
      default: deg_idx = b_r;
    endcase
  end

  assign issue   = (st_r == C_MAC) && (ia_r < n);
  assign load    = (st_r == C_RES) && (!ov_r || out_ready);

  // Rounding and saturation of the dot product; a degenerate pair gives zero.
  always_comb begin
    rnd = (c_r + CAW'(16384)) >>> 15;
    if (rdeg_r) begin
      corr = '0;
    end else if (rnd > SAT_HI) begin
      corr = rcm_pkg::CORR_W'(32767);
    end else if (rnd < SAT_LO) begin
      corr = rcm_pkg::CORR_W'(-32768);
    end else begin
      corr = rnd[rcm_pkg::CORR_W-1:0];
    end
  end

  // Row pair sequencer with a three-stage multiply-accumulate.
  always_comb begin
    st_nxt   = st_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    fin_nxt  = fin_r;
    dega_nxt = dega_r;
    ia_nxt   = ia_r;
    v1_nxt   = issue;
    v2_nxt   = v1_r;
    prod_nxt = v1_r ? 32'(rd_a * rd_b) : prod_r;
    c_nxt    = v2_r ? c_r + CAW'(prod_r) : c_r;
    rdeg_nxt = rdeg_r;
    done     = 1'b0;
    case (st_r)
      C_IDLE: begin
        if (go) begin
          st_nxt  = C_FIRST;
          a_nxt   = a;
          b_nxt   = '0;
          fin_nxt = fin;
        end
      end
      C_FIRST: begin
        dega_nxt = deg_q;
        st_nxt   = C_PAIR;
      end
      C_PAIR: begin
        ia_nxt = '0;
        c_nxt  = '0;
        if (dega_r || deg_q) begin
          rdeg_nxt = 1'b1;
          st_nxt   = C_RES;
        end else begin
          rdeg_nxt = 1'b0;
          st_nxt   = C_MAC;
        end
      end
      C_MAC: begin
        if (issue) begin
          ia_nxt = ia_r + 1'b1;
        end else if (!v1_r && !v2_r) begin
          st_nxt = C_RES;
        end
      end
      C_RES: begin
        if (load) begin
          if (b_r == a_r) begin
            done   = 1'b1;
            st_nxt = C_IDLE;
          end else begin
            b_nxt  = b_r + 1'b1;
            st_nxt = C_PAIR;
          end
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
      ov_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    fin_r  <= fin_nxt;
    dega_r <= dega_nxt;
    ia_r   <= ia_nxt;
    prod_r <= prod_nxt;
    c_r    <= c_nxt;
    rdeg_r <= rdeg_nxt;
    if (load) begin
      oa_r <= a_r;
      ob_r <= b_r;
      oc_r <= corr;
      od_r <= rdeg_r;
      ol_r <= (b_r == a_r);
      om_r <= (b_r == a_r) && fin_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_row_a       = rcm_pkg::ROW_W'(oa_r);
  assign out_row_b       = rcm_pkg::ROW_W'(ob_r);
  assign out_correlation = oc_r;
  assign out_degenerate  = od_r;
  assign out_last        = ol_r;
  assign out_matrix_done = om_r;

endmodule

/* src/row_correlation_matrix.sv */
// Streaming Pearson correlation matrix.
// Input channel (in_valid/in_ready): one signed 16-bit sample per item, row
// after row; in_new_matrix on the first sample of a matrix restarts counting.
// Result channel (out_valid/out_ready): after the last sample of row a, one
// item per stored row b = 0..a, giving the Q1.15 correlation of rows a and b.
// Configuration: APB-style port, cols_in_use at address 0, rows_in_use at 4.
// Samples within a row are taken one per cycle. On the last sample of a row
// the input stalls while the row is normalised and correlated:
//   normalisation is paced by the single sample store read port and the
//   one-bit-per-cycle divider and square-root units;
//   correlation runs one multiply-accumulate a cycle over the two read
//   ports of the row store.
// A stalled receiver holds the output register, which stops the pair
// sequencer; the input opens again once the last result is in that register.
// Reset (synchronous, rst_n low) clears counters and control state and sets
// the registers to 256 columns and 64 rows; the row store needs no clearing.
module row_correlation_matrix #(
  parameter int MAX_ROWS = rcm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = rcm_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rcm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_new_matrix,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rcm_pkg::ROW_W-1:0]           out_row_a,
  output logic [rcm_pkg::ROW_W-1:0]           out_row_b,
  output logic signed [rcm_pkg::CORR_W-1:0]   out_correlation,
  output logic                                out_degenerate,
  output logic                                out_last,
  output logic                                out_matrix_done,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcm_pkg::CFG_AW-1:0]          paddr,
  input  logic [rcm_pkg::CFG_DW-1:0]          pwdata,
  output logic [rcm_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int NW  = $clog2(MAX_COLS + 1);
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int SW  = NW + 16;

  localparam logic [1:0] T_IN   = 2'd0;
  localparam logic [1:0] T_NORM = 2'd1;
  localparam logic [1:0] T_CORR = 2'd2;

  logic [rcm_pkg::COLS_W-1:0] cols_r;
  logic [rcm_pkg::ROWS_W-1:0] rows_r;
  logic [NW-1:0]  n_eff, cc_r, cc_nxt, cc_base, cc_inc;
  logic [RCW-1:0] rows_eff, rc_r, rc_nxt, rc_base, a_ext, a_inc;
  logic signed [SW-1:0] sum_r, sum_nxt, sum_base;
  logic [1:0]     st_r, st_nxt;
  logic [RW-1:0]  a_r, a_nxt;
  logic           fin_r, fin_nxt;
  logic           norm_go_r, norm_go_nxt, corr_go_r, corr_go_nxt;
  logic           accept, cfg_wr, corr_done;
  logic           nw_we;
  logic [RW+CW-1:0] nw_addr;
  logic signed [rcm_pkg::CORR_W-1:0] nw_data;
  rcm_pkg::norm_stat_t stat;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= rcm_pkg::COLS_W'(256);
      rows_r <= rcm_pkg::ROWS_W'(64);
    end else if (cfg_wr) begin
      case (paddr[2])
        rcm_pkg::REG_COLS: cols_r <= pwdata[rcm_pkg::COLS_W-1:0];
        rcm_pkg::REG_ROWS: rows_r <= pwdata[rcm_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rcm_pkg::REG_COLS: prdata = rcm_pkg::CFG_DW'(cols_r);
      rcm_pkg::REG_ROWS: prdata = rcm_pkg::CFG_DW'(rows_r);
      default:           prdata = '0;
    endcase
  end

  // Effective sizes: zero acts as one, oversize as the maximum.
  always_comb begin
    if (cols_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      n_eff = NW'(MAX_COLS);
    end else begin
      n_eff = NW'(cols_r);
    end
    if (rows_r == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = RCW'(rows_r);
    end
  end

  // Sample intake and row bookkeeping.
  assign in_ready = (st_r == T_IN);
  assign accept   = in_valid && in_ready;
  assign cc_base  = in_new_matrix ? '0 : cc_r;
  assign rc_base  = in_new_matrix ? '0 : rc_r;
  assign sum_base = in_new_matrix ? '0 : sum_r;
  assign cc_inc   = cc_base + 1'b1;
  assign a_ext    = (rc_base >= rows_eff) ? '0 : rc_base;
  assign a_inc    = a_ext + 1'b1;

  always_comb begin
    st_nxt      = st_r;
    cc_nxt      = cc_r;
    rc_nxt      = rc_r;
    sum_nxt     = sum_r;
    a_nxt       = a_r;
    fin_nxt     = fin_r;
    norm_go_nxt = 1'b0;
    corr_go_nxt = 1'b0;
    case (st_r)
      T_IN: begin
        if (accept) begin
          sum_nxt = sum_base + SW'(in_sample);
          rc_nxt  = rc_base;
          if (cc_inc < n_eff) begin
            cc_nxt = cc_inc;
          end else begin
            cc_nxt      = '0;
            a_nxt       = RW'(a_ext);
            fin_nxt     = (a_ext == rows_eff - 1'b1);
            rc_nxt      = (a_inc >= rows_eff) ? '0 : a_inc;
            norm_go_nxt = 1'b1;
            st_nxt      = T_NORM;
          end
        end
      end
      T_NORM: begin
        if (stat.done) begin
          corr_go_nxt = 1'b1;
          st_nxt      = T_CORR;
        end
      end
      T_CORR: begin
        if (corr_done) begin
          sum_nxt = '0;
          st_nxt  = T_IN;
        end
      end
      default: st_nxt = T_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= T_IN;
      cc_r      <= '0;
      rc_r      <= '0;
      sum_r     <= '0;
      norm_go_r <= 1'b0;
      corr_go_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cc_r      <= cc_nxt;
      rc_r      <= rc_nxt;
      sum_r     <= sum_nxt;
      norm_go_r <= norm_go_nxt;
      corr_go_r <= corr_go_nxt;
    end
    a_r   <= a_nxt;
    fin_r <= fin_nxt;
  end

  rcm_norm #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_norm (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (norm_go_r),
    .a       (a_r),
    .n       (n_eff),
    .sum     (sum_r),
    .cur_we  (accept),
    .cur_addr(cc_base[CW-1:0]),
    .cur_data(in_sample),
    .nw_we   (nw_we),
    .nw_addr (nw_addr),
    .nw_data (nw_data),
    .stat    (stat)
  );

  rcm_corr #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_corr (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (corr_go_r),
    .a              (a_r),
    .fin            (fin_r),
    .n              (n_eff),
    .nw_we          (nw_we),
    .nw_addr        (nw_addr),
    .nw_data        (nw_data),
    .stat           (stat),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_row_a      (out_row_a),
    .out_row_b      (out_row_b),
    .out_correlation(out_correlation),
    .out_degenerate (out_degenerate),
    .out_last       (out_last),
    .out_matrix_done(out_matrix_done),
    .done           (corr_done)
  );

endmodule

/* verif/row_correlation_matrix_tb.sv */
`timescale 1ns / 1ps

module row_correlation_matrix_tb;

  localparam int NROWS = rcm_pkg::MAX_ROWS_DEF;
  localparam int NCOLS = rcm_pkg::MAX_COLS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 4000;

  typedef struct {
    logic [rcm_pkg::ROW_W-1:0]         row_a;
    logic [rcm_pkg::ROW_W-1:0]         row_b;
    logic signed [rcm_pkg::CORR_W-1:0] corr;
    logic                              deg;
    logic                              last;
    logic                              done;
  } corr_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [rcm_pkg::SAMPLE_W-1:0] in_sample;
  logic in_new_matrix;
  logic out_valid;
  logic out_ready;
  logic [rcm_pkg::ROW_W-1:0] out_row_a;
  logic [rcm_pkg::ROW_W-1:0] out_row_b;
  logic signed [rcm_pkg::CORR_W-1:0] out_correlation;
  logic out_degenerate;
  logic out_last;
  logic out_matrix_done;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rcm_pkg::CFG_AW-1:0] paddr;
  logic [rcm_pkg::CFG_DW-1:0] pwdata;
  logic [rcm_pkg::CFG_DW-1:0] prdata;
  logic pready;

  row_correlation_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample(in_sample), .in_new_matrix(in_new_matrix),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_a(out_row_a), .out_row_b(out_row_b),
    .out_correlation(out_correlation), .out_degenerate(out_degenerate),
    .out_last(out_last), .out_matrix_done(out_matrix_done),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor state: registers, counters and the stored normalised rows.
  logic [rcm_pkg::COLS_W-1:0] cols_reg;
  logic [rcm_pkg::ROWS_W-1:0] rows_reg;
  logic signed [15:0] norm_rows [NROWS][NCOLS];
  bit row_deg [NROWS];
  int cur_row [NCOLS];
  longint row_total;
  int col_cnt;
  int row_cnt;

  corr_result_t pending_corr[$];
  int errors = 0;
  int cycles = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter guards against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic int eff_limit(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned q);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > q) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (q >= res + bitv) begin
        q = q - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Removes the mean of the finished row, scales it to unit length and stores it.
  task automatic normalise_row(int a, int n);
    longint unsigned mag [NCOLS];
    bit neg [NCOLS];
    longint unsigned maxmag;
    longint unsigned q;
    longint unsigned r;
    longint unsigned v;
    longint d;
    int up;
    int down;
    maxmag = 0;
    for (int i = 0; i < n; i++) begin
      d = longint'(n) * longint'(cur_row[i]) - row_total;
      neg[i] = d < 0;
      mag[i] = (d < 0) ? -d : d;
      if (mag[i] > maxmag) maxmag = mag[i];
    end
    for (int i = 0; i < NCOLS; i++) norm_rows[a][i] = '0;
    if (maxmag == 0) begin
      row_deg[a] = 1'b1;
      return;
    end
    row_deg[a] = 1'b0;
    up = 0;
    down = 0;
    while ((maxmag << up) < (64'd1 << 23)) up++;
    while ((maxmag >> down) >= (64'd1 << 24)) down++;
    q = 0;
    for (int i = 0; i < n; i++) begin
      mag[i] = (mag[i] << up) >> down;
      q += mag[i] * mag[i];
    end
    r = int_sqrt(q);
    for (int i = 0; i < n; i++) begin
      v = (mag[i] * 32768 + r / 2) / r;
      if (neg[i]) begin
        if (v > 32768) v = 32768;
        norm_rows[a][i] = -16'(v);
      end else begin
        if (v > 32767) v = 32767;
        norm_rows[a][i] = 16'(v);
      end
    end
  endtask

  function automatic logic signed [15:0] row_dot(int a, int b, int n);
    longint c;
    longint rnd;
    c = 0;
    for (int i = 0; i < n; i++) begin
      c += longint'(norm_rows[a][i]) * longint'(norm_rows[b][i]);
    end
    rnd = (c + 16384) >>> 15;
    if (rnd > 32767) rnd = 32767;
    if (rnd < -32768) rnd = -32768;
    return 16'(rnd);
  endfunction

  // Advances the predictor by one accepted sample and queues the correlations it causes.
  task automatic predict_sample(logic signed [15:0] x, logic newm);
    int n;
    int rows;
    int a;
    corr_result_t e;
    n = eff_limit(int'(cols_reg), NCOLS);
    rows = eff_limit(int'(rows_reg), NROWS);
    if (newm) begin
      col_cnt = 0;
      row_cnt = 0;
      row_total = 0;
    end
    if (col_cnt >= NCOLS) col_cnt = NCOLS - 1;
    cur_row[col_cnt] = x;
    row_total += x;
    col_cnt++;
    if (col_cnt < n) return;
    if (row_cnt >= rows) row_cnt = 0;
    a = row_cnt;
    normalise_row(a, n);
    for (int b = 0; b <= a; b++) begin
      e.row_a = rcm_pkg::ROW_W'(a);
      e.row_b = rcm_pkg::ROW_W'(b);
      e.deg = row_deg[a] || row_deg[b];
      e.corr = e.deg ? 16'sd0 : row_dot(a, b, n);
      e.last = (b == a);
      e.done = (b == a) && (a == rows - 1);
      pending_corr.push_back(e);
    end
    col_cnt = 0;
    row_total = 0;
    row_cnt = a + 1;
    if (row_cnt >= rows) row_cnt = 0;
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) < 70);
    end
  end

  // Checks each accepted result against the oldest predicted correlation.
  always @(posedge clk) begin
    corr_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_corr.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row_a=%0d row_b=%0d corr=%0d", $time,
                 out_row_a, out_row_b, out_correlation);
      end else begin
        e = pending_corr.pop_front();
        if (out_row_a !== e.row_a || out_row_b !== e.row_b || out_correlation !== e.corr ||
            out_degenerate !== e.deg || out_last !== e.last || out_matrix_done !== e.done) begin
          errors++;
          $display("%0t: mismatch expected a=%0d b=%0d c=%0d deg=%0b last=%0b done=%0b",
                   $time, e.row_a, e.row_b, e.corr, e.deg, e.last, e.done);
          $display("%0t:          actual a=%0d b=%0d c=%0d deg=%0b last=%0b done=%0b",
                   $time, out_row_a, out_row_b, out_correlation, out_degenerate, out_last,
                   out_matrix_done);
        end
      end
    end
  end

  // Offers one sample item and waits for it to be taken.
  task automatic send_sample(logic signed [15:0] x, logic newm);
    int gap;
    in_valid <= 1'b1;
    in_sample <= x;
    in_new_matrix <= newm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sample(x, newm);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_corr.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == rcm_pkg::REG_COLS) cols_reg = value[rcm_pkg::COLS_W-1:0];
    else rows_reg = value[rcm_pkg::ROWS_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(int cols, int rows);
    wait_idle();
    write_reg(rcm_pkg::REG_COLS, cols);
    write_reg(rcm_pkg::REG_ROWS, rows);
  endtask

  // Sends one row whose content depends on the chosen style.
  task automatic send_row(int n, bit first);
    int style;
    int base;
    logic signed [15:0] x;
    style = $urandom_range(9);
    base = $urandom_range(65535);
    for (int i = 0; i < n; i++) begin
      case (style)
        0, 1, 2, 3: begin
          x = 16'($urandom_range(65535));
        end
        4, 5: begin
          x = 16'(base + $urandom_range(6));
        end
        6: begin
          x = 16'(base);
        end
        7: begin
          x = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
        end
        default: begin
          x = 16'(i * 1000 - 2000 + $urandom_range(3));
        end
      endcase
      send_sample(x, first && (i == 0));
    end
  endtask

  task automatic test_directed();
    set_shape(3, 3);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    // A constant row has no variance.
    repeat (3) send_sample(16'sd5, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    // A new matrix flagged part-way through a row restarts the counts.
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd200, 1'b1);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd3, 1'b0);
    // A column count of zero acts as one: every row is degenerate.
    set_shape(0, 2);
    send_sample(16'sd9, 1'b1);
    send_sample(-16'sd9, 1'b0);
    // Row count beyond the maximum acts as the maximum.
    set_shape(2, 127);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd2, 1'b0);
  endtask

  task automatic test_long_row();
    set_shape(24, 1);
    send_row(24, 1'b1);
  endtask

  task automatic test_tallest_matrix();
    set_shape(2, 64);
    for (int r = 0; r < 64; r++) send_row(2, r == 0);
  endtask

  task automatic test_random_matrices();
    int sent;
    int cols;
    int rows;
    sent = 0;
    while (sent < 8) begin
      cols = $urandom_range(6, 2);
      rows = $urandom_range(3, 1);
      set_shape(cols, rows);
      for (int r = 0; r < rows; r++) begin
        send_row(cols, (r == 0) && ($urandom_range(3) != 0));
        sent += cols;
      end
    end
  endtask

  // The receiver holds off while the sender keeps pushing rows.
  task automatic test_backpressure();
    set_shape(2, 6);
    hold_req++;
    for (int r = 0; r < 6; r++) send_row(2, r == 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample = '0;
    in_new_matrix = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cols_reg = 9'd256;
    rows_reg = 7'd64;
    row_total = 0;
    col_cnt = 0;
    row_cnt = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_long_row();
    test_tallest_matrix();
    test_backpressure();
    test_random_matrices();
    wait_idle();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_corr.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rcm_pkg.sv
src/rcm_div.sv
src/rcm_norm.sv
src/rcm_corr.sv
src/row_correlation_matrix.sv
verif/row_correlation_matrix_tb.sv
